/* rtl/assert_macros.svh */
// assertion macros used by the checker file
// each macro expects clk and rst_n in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MCT_ASSERT_NOW(label, en, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (en) |-> (cond)) \
    else $error("mct: same-cycle check failed");

// next-cycle implication
`define MCT_ASSERT_NEXT(label, en, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (en) |=> (cond)) \
    else $error("mct: next-cycle check failed");

`endif

/* rtl/mct_pkg.sv */
// shared codes, types and byte classes for the media-type header parser
// no dependencies
`timescale 1ns / 1ps

package mct_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] phase_t;
  typedef logic [2:0] role_t;
  typedef logic [1:0] status_t;

  // parser phases
  localparam phase_t PH_TYPE     = 4'd0;
  localparam phase_t PH_TYPE_TWS = 4'd1;
  localparam phase_t PH_SUB      = 4'd2;
  localparam phase_t PH_SUB_TWS  = 4'd3;
  localparam phase_t PH_KEY      = 4'd4;
  localparam phase_t PH_KEY_TWS  = 4'd5;
  localparam phase_t PH_VAL      = 4'd6;
  localparam phase_t PH_VAL_Q    = 4'd7;
  localparam phase_t PH_VAL_ESC  = 4'd8;
  localparam phase_t PH_VAL_TWS  = 4'd9;
  localparam phase_t PH_ERR      = 4'd10;

  // fold tracking
  localparam logic [1:0] FOLD_NONE = 2'd0;
  localparam logic [1:0] FOLD_CR   = 2'd1;
  localparam logic [1:0] FOLD_CRLF = 2'd2;

  // role and closed codes
  localparam role_t ROLE_SKIP = 3'd0;
  localparam role_t ROLE_TYPE = 3'd1;
  localparam role_t ROLE_SUB  = 3'd2;
  localparam role_t ROLE_KEY  = 3'd3;
  localparam role_t ROLE_VAL  = 3'd4;

  // status codes
  localparam status_t ST_RUN = 2'd0;
  localparam status_t ST_ACC = 2'd1;
  localparam status_t ST_ERR = 2'd2;

  // characters
  localparam byte_t CH_NUL    = 8'h00;
  localparam byte_t CH_TAB    = 8'h09;
  localparam byte_t CH_LF     = 8'h0a;
  localparam byte_t CH_CR     = 8'h0d;
  localparam byte_t CH_SP     = 8'h20;
  localparam byte_t CH_DEL    = 8'h7f;
  localparam byte_t CH_QUOTE  = "\"";
  localparam byte_t CH_BSLASH = "\\";
  localparam byte_t CH_STAR   = "*";
  localparam byte_t CH_SLASH  = "/";
  localparam byte_t CH_SEMI   = ";";
  localparam byte_t CH_EQ     = "=";
  localparam byte_t CH_UP_A   = "A";
  localparam byte_t CH_UP_Z   = "Z";
  localparam byte_t CASE_OFS  = 8'd32;

  typedef struct packed {
    byte_t   out_byte;
    role_t   role;
    role_t   closed;
    status_t status;
  } mct_res_t;

  function automatic logic is_token(byte_t c);
    logic special;
    special = c inside {"(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"",
                        "/", "[", "]", "?", "="};
    return (c > CH_SP) && (c < CH_DEL) && !special;
  endfunction

  function automatic logic is_blank(byte_t c);
    return (c == CH_SP) || (c == CH_TAB);
  endfunction

  function automatic logic is_ctl(byte_t c);
    return ((c < CH_SP) && (c != CH_TAB)) || (c == CH_DEL);
  endfunction

  function automatic byte_t to_lower(byte_t c);
    return ((c >= CH_UP_A) && (c <= CH_UP_Z)) ? c + CASE_OFS : c;
  endfunction

endpackage

/* rtl/mct_core.sv */
// parser state and per-byte decision logic
// depends on mct_pkg
`timescale 1ns / 1ps

module mct_core (
  input  logic                clk,
  input  logic                rst_n,
  input  mct_pkg::byte_t      ch,
  input  logic                step,
  output mct_pkg::mct_res_t   res
);

  mct_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]      fold_r, fold_nxt;
  logic            nonempty_r, nonempty_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= mct_pkg::PH_TYPE;
      fold_r     <= mct_pkg::FOLD_NONE;
      nonempty_r <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      fold_r     <= fold_nxt;
      nonempty_r <= nonempty_nxt;
    end
  end

  always_comb begin
    logic            ok;
    logic            done;
    logic            ws;
    logic            acc;
    mct_pkg::role_t  r;
    mct_pkg::role_t  role;
    mct_pkg::role_t  closed;
    mct_pkg::status_t status;
    mct_pkg::byte_t  b;

    ok           = 1'b1;
    done         = 1'b0;
    acc          = 1'b0;
    ws           = mct_pkg::is_blank(ch) || (ch == mct_pkg::CH_CR);
    role         = mct_pkg::ROLE_SKIP;
    closed       = mct_pkg::ROLE_SKIP;
    status       = mct_pkg::ST_RUN;
    b            = ch;
    phase_nxt    = phase_r;
    fold_nxt     = fold_r;
    nonempty_nxt = nonempty_r;
    r = (phase_r == mct_pkg::PH_TYPE) ? mct_pkg::ROLE_TYPE :
        (phase_r == mct_pkg::PH_SUB)  ? mct_pkg::ROLE_SUB  : mct_pkg::ROLE_KEY;

    if (ch == mct_pkg::CH_NUL) begin
      // terminator: verdict, then back to reset state
      if (phase_r != mct_pkg::PH_ERR && fold_r == mct_pkg::FOLD_NONE) begin
        if (phase_r == mct_pkg::PH_SUB && nonempty_r) begin
          acc = 1'b1;
          closed = mct_pkg::ROLE_SUB;
        end else if (phase_r == mct_pkg::PH_VAL && nonempty_r) begin
          acc = 1'b1;
          closed = mct_pkg::ROLE_VAL;
        end else if (phase_r == mct_pkg::PH_SUB_TWS || phase_r == mct_pkg::PH_VAL_TWS ||
                     (phase_r == mct_pkg::PH_KEY && !nonempty_r)) begin
          acc = 1'b1;
        end
      end
      if (!acc) closed = mct_pkg::ROLE_SKIP;
      status       = acc ? mct_pkg::ST_ACC : mct_pkg::ST_ERR;
      phase_nxt    = mct_pkg::PH_TYPE;
      fold_nxt     = mct_pkg::FOLD_NONE;
      nonempty_nxt = 1'b0;
    end else if (phase_r == mct_pkg::PH_ERR) begin
      status = mct_pkg::ST_ERR;
    end else begin
      if (fold_r == mct_pkg::FOLD_CR) begin
        if (ch == mct_pkg::CH_LF) begin
          fold_nxt = mct_pkg::FOLD_CRLF;
          done = 1'b1;
        end else ok = 1'b0;
      end else if (fold_r == mct_pkg::FOLD_CRLF) begin
        if (mct_pkg::is_blank(ch)) begin
          fold_nxt = mct_pkg::FOLD_NONE;
          done = 1'b1;
        end else ok = 1'b0;
      end

      if (ok && !done) begin
        case (phase_r)
          mct_pkg::PH_TYPE, mct_pkg::PH_SUB, mct_pkg::PH_KEY: begin
            if (!nonempty_r) begin
              if (ws) begin
              end else if (phase_r == mct_pkg::PH_KEY && ch == mct_pkg::CH_STAR) begin
                ok = 1'b0;
              end else if (mct_pkg::is_token(ch)) begin
                nonempty_nxt = 1'b1;
                role = r;
                b = mct_pkg::to_lower(ch);
              end else ok = 1'b0;
            end else if (phase_r == mct_pkg::PH_KEY && ch == mct_pkg::CH_STAR) begin
              ok = 1'b0;
            end else if (mct_pkg::is_token(ch)) begin
              role = r;
              b = mct_pkg::to_lower(ch);
            end else if (ws) begin
              closed = r;
              phase_nxt = phase_r + 4'd1;
              nonempty_nxt = 1'b0;
            end else if (phase_r == mct_pkg::PH_TYPE && ch == mct_pkg::CH_SLASH) begin
              closed = mct_pkg::ROLE_TYPE;
              phase_nxt = mct_pkg::PH_SUB;
              nonempty_nxt = 1'b0;
            end else if (phase_r == mct_pkg::PH_SUB && ch == mct_pkg::CH_SEMI) begin
              closed = mct_pkg::ROLE_SUB;
              phase_nxt = mct_pkg::PH_KEY;
              nonempty_nxt = 1'b0;
            end else if (phase_r == mct_pkg::PH_KEY && ch == mct_pkg::CH_EQ) begin
              closed = mct_pkg::ROLE_KEY;
              phase_nxt = mct_pkg::PH_VAL;
              nonempty_nxt = 1'b0;
            end else ok = 1'b0;
          end
          mct_pkg::PH_TYPE_TWS: begin
            if (ws) begin
            end else if (ch == mct_pkg::CH_SLASH) begin
              phase_nxt = mct_pkg::PH_SUB;
              nonempty_nxt = 1'b0;
            end else ok = 1'b0;
          end
          mct_pkg::PH_SUB_TWS, mct_pkg::PH_VAL_TWS: begin
            if (ws) begin
            end else if (ch == mct_pkg::CH_SEMI) begin
              phase_nxt = mct_pkg::PH_KEY;
              nonempty_nxt = 1'b0;
            end else ok = 1'b0;
          end
          mct_pkg::PH_KEY_TWS: begin
            if (ws) begin
            end else if (ch == mct_pkg::CH_EQ) begin
              phase_nxt = mct_pkg::PH_VAL;
              nonempty_nxt = 1'b0;
            end else ok = 1'b0;
          end
          mct_pkg::PH_VAL: begin
            if (!nonempty_r) begin
              if (ws) begin
              end else if (ch == mct_pkg::CH_QUOTE) begin
                phase_nxt = mct_pkg::PH_VAL_Q;
                nonempty_nxt = 1'b0;
              end else if (mct_pkg::is_token(ch)) begin
                nonempty_nxt = 1'b1;
                role = mct_pkg::ROLE_VAL;
              end else ok = 1'b0;
            end else if (mct_pkg::is_token(ch)) begin
              role = mct_pkg::ROLE_VAL;
            end else if (ws) begin
              closed = mct_pkg::ROLE_VAL;
              phase_nxt = mct_pkg::PH_VAL_TWS;
              nonempty_nxt = 1'b0;
            end else if (ch == mct_pkg::CH_SEMI) begin
              closed = mct_pkg::ROLE_VAL;
              phase_nxt = mct_pkg::PH_KEY;
              nonempty_nxt = 1'b0;
            end else ok = 1'b0;
          end
          mct_pkg::PH_VAL_Q: begin
            if (ch == mct_pkg::CH_QUOTE) begin
              closed = mct_pkg::ROLE_VAL;
              phase_nxt = mct_pkg::PH_VAL_TWS;
              nonempty_nxt = 1'b0;
            end else if (ch == mct_pkg::CH_BSLASH) begin
              phase_nxt = mct_pkg::PH_VAL_ESC;
            end else if (mct_pkg::is_ctl(ch)) begin
              ok = 1'b0;
            end else role = mct_pkg::ROLE_VAL;
          end
          mct_pkg::PH_VAL_ESC: begin
            if (mct_pkg::is_ctl(ch)) ok = 1'b0;
            else begin
              role = mct_pkg::ROLE_VAL;
              phase_nxt = mct_pkg::PH_VAL_Q;
            end
          end
          default: ok = 1'b0;
        endcase
        if (ok && ch == mct_pkg::CH_CR) fold_nxt = mct_pkg::FOLD_CR;
      end

      if (!ok) begin
        phase_nxt    = mct_pkg::PH_ERR;
        fold_nxt     = mct_pkg::FOLD_NONE;
        nonempty_nxt = 1'b0;
        status       = mct_pkg::ST_ERR;
        role         = mct_pkg::ROLE_SKIP;
        closed       = mct_pkg::ROLE_SKIP;
      end
    end

    res.out_byte = (role != mct_pkg::ROLE_SKIP) ? b : mct_pkg::CH_NUL;
    res.role     = role;
    res.closed   = closed;
    res.status   = status;
  end

endmodule

/* rtl/mime_content_type_parser.sv */
// Media-type header parser, one header byte per beat, one result beat per
// input beat. The byte is registered, decoded against the parser state and
// the result registered. Sustained rate is one byte per cycle while the
// output is not stalled, set by the state update in mct_core; an input
// register lets one byte wait while a result is stalled. A zero byte ends
// the header, carries the verdict and returns the parser to its reset state.
// top level of the parser; depends on mct_pkg and mct_core
`timescale 1ns / 1ps

module mime_content_type_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mct_pkg::byte_t       in_ch,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mct_pkg::byte_t       out_byte,
  output mct_pkg::role_t       out_role,
  output mct_pkg::role_t       out_closed,
  output mct_pkg::status_t     out_status
);

  mct_pkg::byte_t    ch_r;
  logic              ch_vld_r, ch_vld_nxt;
  logic              out_vld_r, out_vld_nxt;
  mct_pkg::mct_res_t res_r;
  mct_pkg::mct_res_t res_nxt;
  logic              advance;
  logic              in_take;

  assign advance  = ch_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = ch_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    ch_vld_nxt  = in_take ? 1'b1 : (advance ? 1'b0 : ch_vld_r);
    out_vld_nxt = advance ? 1'b1 : (out_vld_r && out_stall);
  end

  mct_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .ch    (ch_r),
    .step  (advance),
    .res   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      ch_vld_r  <= ch_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) ch_r <= in_ch;
    if (advance) res_r <= res_nxt;
  end

  assign out_valid  = out_vld_r;
  assign out_byte   = res_r.out_byte;
  assign out_role   = res_r.role;
  assign out_closed = res_r.closed;
  assign out_status = res_r.status;

endmodule

/* rtl/mct_checker.sv */
// port-level checks for the media-type header parser, bound to the top level
// depends on mct_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mct_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  mct_pkg::byte_t       out_byte,
  input  mct_pkg::role_t       out_role,
  input  mct_pkg::role_t       out_closed,
  input  mct_pkg::status_t     out_status
);

  // stalled result beat holds
  `MCT_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_byte) && $stable(out_role) && $stable(out_closed) &&
    $stable(out_status))

  // skipped bytes carry no content
  `MCT_ASSERT_NOW(a_skip_zero, out_valid && out_role == mct_pkg::ROLE_SKIP,
    out_byte == mct_pkg::CH_NUL)

  // verdict beat is never a content byte
  `MCT_ASSERT_NOW(a_acc_skip, out_valid && out_status == mct_pkg::ST_ACC,
    out_role == mct_pkg::ROLE_SKIP)

  // error beats report nothing else
  `MCT_ASSERT_NOW(a_err_quiet, out_valid && out_status == mct_pkg::ST_ERR,
    out_role == mct_pkg::ROLE_SKIP && out_closed == mct_pkg::ROLE_SKIP)

  // type and key never close at the terminator
  `MCT_ASSERT_NOW(a_close_type_run,
    out_valid && (out_closed == mct_pkg::ROLE_TYPE || out_closed == mct_pkg::ROLE_KEY),
    out_status == mct_pkg::ST_RUN)

endmodule

bind mime_content_type_parser mct_checker u_mct_checker (.*);

/* tb/mime_content_type_parser_tb.sv */
// self-checking testbench for mime_content_type_parser: directed table, then random headers
// predicts result beats in-line (typed directed rows carry their own) and compares field by field; depends on mct_pkg
`timescale 1ns / 1ps

module mime_content_type_parser_tb;
  import mct_pkg::*;

  typedef struct {
    byte_t   ch;
    bit      typed;
    byte_t   e_byte;
    role_t   e_role;
    role_t   e_closed;
    status_t e_status;
  } dir_row_t;

  localparam int DIR_ROWS = 28;

  // rows with typed = 1 carry their own expected beat, the rest use the predictor
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{CH_NUL,    1'b1, CH_NUL, ROLE_SKIP, ROLE_SKIP, ST_ERR},
    '{"A",       1'b1, "a",    ROLE_TYPE, ROLE_SKIP, ST_RUN},
    '{CH_SLASH,  1'b0, CH_NUL, ROLE_SKIP, ROLE_SKIP, ST_RUN},
    '{"Z",       1'b0, CH_NUL, ROLE_SKIP, ROLE_SKIP, ST_RUN},
    '{CH_CR,     1'b0, CH_NUL, ROLE_SKIP, ROLE_SKIP, ST_RUN},
    '{CH_LF,     1'b0, CH_NUL, ROLE_SKIP, ROLE_SKIP, ST_RUN},
    '{CH_TAB,    1'b0, CH_NUL, ROLE_SKIP, ROLE_SKIP, ST_RUN},
    '{CH_SEMI,   1'b0, CH_NUL, ROLE_SKIP, ROLE_SKIP, ST_RUN},
    '{CH_SEMI,   1'b1, CH_NUL, ROLE_SKIP, ROLE_SKIP, ST_ERR},
    '{CH_NUL,    1'b1, CH_NUL, ROLE_SKIP, ROLE_SKIP, ST_ERR},
    '{"x",       1'b0, CH_NUL, ROLE_SKIP, ROLE_SKIP, ST_RUN},
    '{CH_SLASH,  1'b0, CH_NUL, ROLE_SKIP, ROLE_SKIP, ST_RUN},
    '{"y",       1'b0, CH_NUL, ROLE_SKIP, ROLE_SKIP, ST_RUN},
    '{CH_SEMI,   1'b0, CH_NUL, ROLE_SKIP, ROLE_SKIP, ST_RUN},
    '{"K",       1'b0, CH_NUL, ROLE_SKIP, ROLE_SKIP, ST_RUN},
    '{CH_EQ,     1'b0, CH_NUL, ROLE_SKIP, ROLE_SKIP, ST_RUN},
    '{CH_QUOTE,  1'b0, CH_NUL, ROLE_SKIP, ROLE_SKIP, ST_RUN},
    '{CH_BSLASH, 1'b0, CH_NUL, ROLE_SKIP, ROLE_SKIP, ST_RUN},
    '{8'hff,     1'b1, 8'hff,  ROLE_VAL,  ROLE_SKIP, ST_RUN},
    '{CH_QUOTE,  1'b0, CH_NUL, ROLE_SKIP, ROLE_SKIP, ST_RUN},
    '{CH_NUL,    1'b1, CH_NUL, ROLE_SKIP, ROLE_SKIP, ST_ACC},
    '{"a",       1'b0, CH_NUL, ROLE_SKIP, ROLE_SKIP, ST_RUN},
    '{CH_SLASH,  1'b0, CH_NUL, ROLE_SKIP, ROLE_SKIP, ST_RUN},
    '{"b",       1'b0, CH_NUL, ROLE_SKIP, ROLE_SKIP, ST_RUN},
    '{CH_SEMI,   1'b0, CH_NUL, ROLE_SKIP, ROLE_SKIP, ST_RUN},
    '{CH_STAR,   1'b1, CH_NUL, ROLE_SKIP, ROLE_SKIP, ST_ERR},
    '{CH_DEL,    1'b1, CH_NUL, ROLE_SKIP, ROLE_SKIP, ST_ERR},
    '{CH_NUL,    1'b1, CH_NUL, ROLE_SKIP, ROLE_SKIP, ST_ERR}
  };

  logic    clk;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  byte_t   in_ch = CH_NUL;
  logic    in_stall;
  logic    out_valid;
  logic    out_stall = 1'b0;
  byte_t   out_byte;
  role_t   out_role;
  role_t   out_closed;
  status_t out_status;

  mct_res_t expected_q [$];
  byte_t    hdr_q [$];

  // parser state as the predictor sees it
  phase_t     hp_phase = PH_TYPE;
  logic [1:0] hp_fold = FOLD_NONE;
  logic       hp_begun = 1'b0;

  int mismatches = 0;
  int beats_sent = 0;
  int hold_left = 0;
  bit idle_on = 1'b1;

  mime_content_type_parser DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_ch      (in_ch),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_role   (out_role),
    .out_closed (out_closed),
    .out_status (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic bit tok_char(byte_t c);
    if ((c <= CH_SP) || (c >= CH_DEL)) return 1'b0;
    case (c)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?", "=": begin
        return 1'b0;
      end
      default: return 1'b1;
    endcase
  endfunction

  function automatic bit ctl_char(byte_t c);
    return ((c < CH_SP) && (c != CH_TAB)) || (c == CH_DEL);
  endfunction

  // advances the predicted parser state by one header byte
  function automatic mct_res_t parse_step(byte_t c);
    mct_res_t r;
    role_t    rl;
    role_t    cl;
    role_t    own;
    byte_t    b;
    bit       ok;
    bit       ws;
    bit       acc;
    r  = '0;
    rl = ROLE_SKIP;
    cl = ROLE_SKIP;
    b  = c;
    ok = 1'b1;
    if (c == CH_NUL) begin
      acc = 1'b0;
      if ((hp_phase != PH_ERR) && (hp_fold == FOLD_NONE)) begin
        if ((hp_phase == PH_SUB) && hp_begun) begin
          acc = 1'b1;
          cl = ROLE_SUB;
        end else if ((hp_phase == PH_VAL) && hp_begun) begin
          acc = 1'b1;
          cl = ROLE_VAL;
        end else if ((hp_phase == PH_SUB_TWS) || (hp_phase == PH_VAL_TWS) ||
                     ((hp_phase == PH_KEY) && !hp_begun)) begin
          acc = 1'b1;
        end
      end
      hp_phase = PH_TYPE;
      hp_fold  = FOLD_NONE;
      hp_begun = 1'b0;
      r.closed = acc ? cl : ROLE_SKIP;
      r.status = acc ? ST_ACC : ST_ERR;
      return r;
    end
    if (hp_phase == PH_ERR) begin
      r.status = ST_ERR;
      return r;
    end
    if (hp_fold == FOLD_CR) begin
      if (c == CH_LF) begin
        hp_fold = FOLD_CRLF;
        return r;
      end
      ok = 1'b0;
    end else if (hp_fold == FOLD_CRLF) begin
      if ((c == CH_SP) || (c == CH_TAB)) begin
        hp_fold = FOLD_NONE;
        return r;
      end
      ok = 1'b0;
    end
    if (ok) begin
      ws = (c == CH_SP) || (c == CH_TAB) || (c == CH_CR);
      case (hp_phase)
        PH_TYPE, PH_SUB, PH_KEY: begin
          own = (hp_phase == PH_TYPE) ? ROLE_TYPE : (hp_phase == PH_SUB) ? ROLE_SUB : ROLE_KEY;
          if ((hp_phase == PH_KEY) && (c == CH_STAR)) begin
            ok = 1'b0;
          end else if (tok_char(c)) begin
            hp_begun = 1'b1;
            rl = own;
            b = ((c >= CH_UP_A) && (c <= CH_UP_Z)) ? c + CASE_OFS : c;
          end else if (!hp_begun) begin
            ok = ws;
          end else if (ws) begin
            cl = own;
            hp_phase = phase_t'(hp_phase + 1);
            hp_begun = 1'b0;
          end else if ((hp_phase == PH_TYPE) && (c == CH_SLASH)) begin
            cl = own;
            hp_phase = PH_SUB;
            hp_begun = 1'b0;
          end else if ((hp_phase == PH_SUB) && (c == CH_SEMI)) begin
            cl = own;
            hp_phase = PH_KEY;
            hp_begun = 1'b0;
          end else if ((hp_phase == PH_KEY) && (c == CH_EQ)) begin
            cl = own;
            hp_phase = PH_VAL;
            hp_begun = 1'b0;
          end else begin
            ok = 1'b0;
          end
        end
        PH_TYPE_TWS: begin
          if (!ws) begin
            if (c == CH_SLASH) begin
              hp_phase = PH_SUB;
              hp_begun = 1'b0;
            end else ok = 1'b0;
          end
        end
        PH_SUB_TWS, PH_VAL_TWS: begin
          if (!ws) begin
            if (c == CH_SEMI) begin
              hp_phase = PH_KEY;
              hp_begun = 1'b0;
            end else ok = 1'b0;
          end
        end
        PH_KEY_TWS: begin
          if (!ws) begin
            if (c == CH_EQ) begin
              hp_phase = PH_VAL;
              hp_begun = 1'b0;
            end else ok = 1'b0;
          end
        end
        PH_VAL: begin
          if (!hp_begun) begin
            if (ws) begin
            end else if (c == CH_QUOTE) begin
              hp_phase = PH_VAL_Q;
              hp_begun = 1'b0;
            end else if (tok_char(c)) begin
              hp_begun = 1'b1;
              rl = ROLE_VAL;
            end else ok = 1'b0;
          end else if (tok_char(c)) begin
            rl = ROLE_VAL;
          end else if (ws) begin
            cl = ROLE_VAL;
            hp_phase = PH_VAL_TWS;
            hp_begun = 1'b0;
          end else if (c == CH_SEMI) begin
            cl = ROLE_VAL;
            hp_phase = PH_KEY;
            hp_begun = 1'b0;
          end else ok = 1'b0;
        end
        PH_VAL_Q: begin
          if (c == CH_QUOTE) begin
            cl = ROLE_VAL;
            hp_phase = PH_VAL_TWS;
            hp_begun = 1'b0;
          end else if (c == CH_BSLASH) begin
            hp_phase = PH_VAL_ESC;
          end else if (ctl_char(c)) begin
            ok = 1'b0;
          end else rl = ROLE_VAL;
        end
        PH_VAL_ESC: begin
          if (ctl_char(c)) ok = 1'b0;
          else begin
            rl = ROLE_VAL;
            hp_phase = PH_VAL_Q;
          end
        end
        default: ok = 1'b0;
      endcase
      if (ok && (c == CH_CR)) hp_fold = FOLD_CR;
    end
    if (!ok) begin
      hp_phase = PH_ERR;
      hp_fold  = FOLD_NONE;
      hp_begun = 1'b0;
      r.status = ST_ERR;
      return r;
    end
    r.out_byte = (rl != ROLE_SKIP) ? b : CH_NUL;
    r.role     = rl;
    r.closed   = cl;
    r.status   = ST_RUN;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t: %s got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic push_byte(input byte_t b, input bit typed, input mct_res_t given);
    mct_res_t pred;
    if (idle_on && ($urandom_range(0, 4) == 0)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ch <= b;
    do @(posedge clk); while (in_stall);
    pred = parse_step(b);
    expected_q.push_back(typed ? given : pred);
    beats_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  // optional linear white space, folds included
  task automatic add_lws();
    int n;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: hdr_q.push_back(CH_SP);
        1: hdr_q.push_back(CH_TAB);
        default: begin
          hdr_q.push_back(CH_CR);
          hdr_q.push_back(CH_LF);
          hdr_q.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
        end
      endcase
    end
  endtask

  task automatic add_token();
    int    len;
    byte_t c;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
    repeat (len) begin
      do c = byte_t'($urandom_range(33, 126)); while (!tok_char(c));
      hdr_q.push_back(c);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n || !idle_on) begin
      hold_left = 0;
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      hold_left = $urandom_range(1, 10) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    mct_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("beat with nothing expected", out_byte, CH_NUL);
      end else begin
        want = expected_q.pop_front();
        if (out_byte !== want.out_byte) report_mismatch("out_byte", out_byte, want.out_byte);
        if (out_role !== want.role)
          report_mismatch("out_role", 8'(out_role), 8'(want.role));
        if (out_closed !== want.closed)
          report_mismatch("out_closed", 8'(out_closed), 8'(want.closed));
        if (out_status !== want.status)
          report_mismatch("out_status", 8'(out_status), 8'(want.status));
      end
    end
  end

  initial begin
    int    i;
    int    k;
    int    n;
    int    pos;
    bit    esc;
    bit    mid_drained;
    byte_t c;
    mid_drained = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < DIR_ROWS; i++) begin
      push_byte(dir_tab[i].ch, dir_tab[i].typed,
                '{dir_tab[i].e_byte, dir_tab[i].e_role, dir_tab[i].e_closed,
                  dir_tab[i].e_status});
    end
    wait_drained();

    while (beats_sent < 450) begin
      idle_on = (beats_sent < 370) && ($urandom_range(0, 3) != 0);
      if (!mid_drained && (beats_sent > 220)) begin
        wait_drained();
        mid_drained = 1'b1;
      end
      // well-formed header with random content
      hdr_q.delete();
      add_lws();
      add_token();
      add_lws();
      hdr_q.push_back(CH_SLASH);
      add_lws();
      add_token();
      n = $urandom_range(0, 2);
      for (k = 0; k < n; k++) begin
        add_lws();
        hdr_q.push_back(CH_SEMI);
        add_lws();
        add_token();
        add_lws();
        hdr_q.push_back(CH_EQ);
        add_lws();
        if ($urandom_range(0, 1)) begin
          add_token();
        end else begin
          hdr_q.push_back(CH_QUOTE);
          repeat ($urandom_range(0, 4)) begin
            esc = ($urandom_range(0, 3) == 0);
            do c = byte_t'($urandom_range(9, 255));
            while (ctl_char(c) || (!esc && ((c == CH_QUOTE) || (c == CH_BSLASH))));
            if (esc) hdr_q.push_back(CH_BSLASH);
            hdr_q.push_back(c);
          end
          hdr_q.push_back(CH_QUOTE);
        end
      end
      add_lws();
      if ($urandom_range(0, 7) == 0) begin
        hdr_q.push_back(CH_SEMI);
        add_lws();
      end
      // damage about a third of the headers
      pos = $urandom_range(0, hdr_q.size() - 1);
      case ($urandom_range(0, 11))
        0: begin
          hdr_q.delete();
          repeat ($urandom_range(1, 8)) hdr_q.push_back(byte_t'($urandom_range(1, 255)));
        end
        1: hdr_q[pos] = byte_t'($urandom_range(1, 255));
        2: while (hdr_q.size() > pos) void'(hdr_q.pop_back());
        3: hdr_q.insert(pos, byte_t'($urandom_range(1, 255)));
        default: begin
        end
      endcase
      for (i = 0; i < hdr_q.size(); i++) push_byte(hdr_q[i], 1'b0, '0);
      push_byte(CH_NUL, 1'b0, '0);
    end

    in_valid <= 1'b0;
    for (k = 0; (k < 4000) && (expected_q.size() != 0); k++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_q.size() != 0)
      report_mismatch("beats never returned", 8'(expected_q.size()), 8'd0);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
